@@ rtl/nif_pkg.sv @@
// ----------------------------------------------------------------------------
// nif_pkg
// Shared types and constants of the infrared frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nif_pkg;

    localparam int unsigned TICK_W  = 15;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned CFG_A_W = 3;

    localparam logic [TICK_W-1:0] SPACE_TOL     = TICK_W'(300);
    localparam logic [IDX_W-1:0]  FRAME_SYMBOLS = IDX_W'(33);

    localparam logic [TICK_W-1:0] RST_HDR_MARK_NOM  = TICK_W'(9000);
    localparam logic [TICK_W-1:0] RST_HDR_MARK_TOL  = TICK_W'(1000);
    localparam logic [TICK_W-1:0] RST_HDR_SPACE_NOM = TICK_W'(4500);
    localparam logic [TICK_W-1:0] RST_HDR_SPACE_TOL = TICK_W'(500);
    localparam logic [TICK_W-1:0] RST_BIT_MARK_NOM  = TICK_W'(562);
    localparam logic [TICK_W-1:0] RST_BIT_MARK_TOL  = TICK_W'(200);
    localparam logic [TICK_W-1:0] RST_ONE_SPACE_NOM = TICK_W'(1687);
    localparam logic [TICK_W-1:0] RST_ZERO_SPACE_NOM = TICK_W'(562);

    typedef enum logic [CFG_A_W-1:0] {
        CFG_HDR_MARK_NOM   = 3'd0,
        CFG_HDR_MARK_TOL   = 3'd1,
        CFG_HDR_SPACE_NOM  = 3'd2,
        CFG_HDR_SPACE_TOL  = 3'd3,
        CFG_BIT_MARK_NOM   = 3'd4,
        CFG_BIT_MARK_TOL   = 3'd5,
        CFG_ONE_SPACE_NOM  = 3'd6,
        CFG_ZERO_SPACE_NOM = 3'd7
    } t_cfg_reg;

    // window results for one symbol
    typedef struct packed {
        logic hdr_ok;
        logic bit_mark_ok;
        logic one_ok;
        logic zero_ok;
    } t_sym_chk;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] address_word;
        logic [WORD_W-1:0] command_word;
    } t_frame_res;

endpackage

`default_nettype wire

@@ rtl/nif_window.sv @@
// ----------------------------------------------------------------------------
// nif_window
// Inclusive duration window check, lower bound clamped at zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nif_window (
    input  wire logic [nif_pkg::TICK_W-1:0] i_value,
    input  wire logic [nif_pkg::TICK_W-1:0] i_nominal,
    input  wire logic [nif_pkg::TICK_W-1:0] i_tolerance,
    output logic                            o_in_window
);
    import nif_pkg::*;

    logic [TICK_W-1:0] lo;
    logic [TICK_W:0]   hi;

    always_comb begin
        lo = (i_nominal > i_tolerance) ? (i_nominal - i_tolerance) : '0;
        hi = {1'b0, i_nominal} + {1'b0, i_tolerance};
        o_in_window = (i_value >= lo) && ({1'b0, i_value} <= hi);
    end

endmodule

`default_nettype wire

@@ rtl/nif_frame.sv @@
// ----------------------------------------------------------------------------
// nif_frame
// Frame state: symbol count, packed data bits and failure flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nif_frame (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic              i_last,
    input  wire nif_pkg::t_sym_chk i_chk,
    output nif_pkg::t_frame_res    o_res
);
    import nif_pkg::*;

    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_bits;
    logic              r_failed;

    logic [IDX_W-1:0]  n_idx;
    logic [DATA_W-1:0] n_bits;
    logic              n_failed;
    logic              is_hdr;
    logic              is_data;
    logic [IDX_W-1:0]  bit_pos;
    logic              ok;

    always_comb begin
        is_hdr  = (r_idx == '0);
        is_data = !is_hdr && (r_idx < FRAME_SYMBOLS);
        bit_pos = r_idx - IDX_W'(1);

        n_failed = r_failed
                 | (is_hdr & !i_chk.hdr_ok)
                 | (is_data & (!i_chk.bit_mark_ok | (!i_chk.one_ok & !i_chk.zero_ok)));

        n_bits = r_bits;
        if (is_data && i_chk.bit_mark_ok && i_chk.one_ok) begin
            n_bits[bit_pos[4:0]] = 1'b1;
        end

        n_idx = (r_idx < FRAME_SYMBOLS) ? (r_idx + IDX_W'(1)) : r_idx;

        ok = !n_failed && (n_idx == FRAME_SYMBOLS);
        o_res.ok           = ok;
        o_res.address_word = ok ? n_bits[WORD_W-1:0] : '0;
        o_res.command_word = ok ? n_bits[DATA_W-1:WORD_W] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_bits   <= '0;
            r_failed <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_idx    <= '0;
                r_bits   <= '0;
                r_failed <= 1'b0;
            end else begin
                r_idx    <= n_idx;
                r_bits   <= n_bits;
                r_failed <= n_failed;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/nec_ir_frame_decoder.sv @@
// path: an accepted input beat passes the input register and then the result register
// throughput: one symbol per cycle, set by the single window-check and frame-update stage
// while a result beat waits stalled, the input register takes one more beat and then stalls
// reset: synchronous active low; clears frame state and valids, loads register defaults
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// Decodes captured mark/space symbols into an address and command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [nif_pkg::CFG_A_W-1:0]   i_cfg_index,
    input  wire logic [nif_pkg::TICK_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [nif_pkg::TICK_W-1:0]    i_mark_ticks,
    input  wire logic [nif_pkg::TICK_W-1:0]    i_space_ticks,
    input  wire logic                          i_last_symbol,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_decoded_ok,
    output logic [nif_pkg::WORD_W-1:0]         o_address_word,
    output logic [nif_pkg::WORD_W-1:0]         o_command_word
);
    import nif_pkg::*;

    logic [TICK_W-1:0] r_hdr_mark_nom;
    logic [TICK_W-1:0] r_hdr_mark_tol;
    logic [TICK_W-1:0] r_hdr_space_nom;
    logic [TICK_W-1:0] r_hdr_space_tol;
    logic [TICK_W-1:0] r_bit_mark_nom;
    logic [TICK_W-1:0] r_bit_mark_tol;
    logic [TICK_W-1:0] r_one_space_nom;
    logic [TICK_W-1:0] r_zero_space_nom;

    logic              r_in_vld;
    logic [TICK_W-1:0] r_mark;
    logic [TICK_W-1:0] r_space;
    logic              r_last;

    logic              r_out_vld;
    t_frame_res        r_res;

    logic              can_fwd;
    logic              fire;
    logic              in_take;
    logic              hdr_mark_ok;
    logic              hdr_space_ok;
    t_sym_chk          chk;
    t_frame_res        n_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mark_nom   <= RST_HDR_MARK_NOM;
            r_hdr_mark_tol   <= RST_HDR_MARK_TOL;
            r_hdr_space_nom  <= RST_HDR_SPACE_NOM;
            r_hdr_space_tol  <= RST_HDR_SPACE_TOL;
            r_bit_mark_nom   <= RST_BIT_MARK_NOM;
            r_bit_mark_tol   <= RST_BIT_MARK_TOL;
            r_one_space_nom  <= RST_ONE_SPACE_NOM;
            r_zero_space_nom <= RST_ZERO_SPACE_NOM;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_HDR_MARK_NOM:   r_hdr_mark_nom   <= i_cfg_data;
                CFG_HDR_MARK_TOL:   r_hdr_mark_tol   <= i_cfg_data;
                CFG_HDR_SPACE_NOM:  r_hdr_space_nom  <= i_cfg_data;
                CFG_HDR_SPACE_TOL:  r_hdr_space_tol  <= i_cfg_data;
                CFG_BIT_MARK_NOM:   r_bit_mark_nom   <= i_cfg_data;
                CFG_BIT_MARK_TOL:   r_bit_mark_tol   <= i_cfg_data;
                CFG_ONE_SPACE_NOM:  r_one_space_nom  <= i_cfg_data;
                CFG_ZERO_SPACE_NOM: r_zero_space_nom <= i_cfg_data;
                default:            r_hdr_mark_nom   <= r_hdr_mark_nom;
            endcase
        end
    end

    always_comb begin
        can_fwd    = !r_out_vld || !i_out_stall;
        fire       = r_in_vld && can_fwd;
        o_in_stall = r_in_vld && !can_fwd;
        in_take    = i_in_valid && !o_in_stall;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (can_fwd) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mark  <= i_mark_ticks;
            r_space <= i_space_ticks;
            r_last  <= i_last_symbol;
        end
    end

    nif_window u_hdr_mark (
        .i_value     (r_mark),
        .i_nominal   (r_hdr_mark_nom),
        .i_tolerance (r_hdr_mark_tol),
        .o_in_window (hdr_mark_ok)
    );

    nif_window u_hdr_space (
        .i_value     (r_space),
        .i_nominal   (r_hdr_space_nom),
        .i_tolerance (r_hdr_space_tol),
        .o_in_window (hdr_space_ok)
    );

    nif_window u_bit_mark (
        .i_value     (r_mark),
        .i_nominal   (r_bit_mark_nom),
        .i_tolerance (r_bit_mark_tol),
        .o_in_window (chk.bit_mark_ok)
    );

    nif_window u_one_space (
        .i_value     (r_space),
        .i_nominal   (r_one_space_nom),
        .i_tolerance (SPACE_TOL),
        .o_in_window (chk.one_ok)
    );

    nif_window u_zero_space (
        .i_value     (r_space),
        .i_nominal   (r_zero_space_nom),
        .i_tolerance (SPACE_TOL),
        .o_in_window (chk.zero_ok)
    );

    assign chk.hdr_ok = hdr_mark_ok && hdr_space_ok;

    nif_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_last  (r_last),
        .i_chk   (chk),
        .o_res   (n_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (can_fwd) begin
            r_out_vld <= fire && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_last) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_decoded_ok   = r_res.ok;
    assign o_address_word = r_res.address_word;
    assign o_command_word = r_res.command_word;

endmodule

`default_nettype wire

@@ rtl/nif_checker.sv @@
// ----------------------------------------------------------------------------
// nif_checker
// Port-level checks of the infrared frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nif_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_in_stall,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic                      o_decoded_ok,
    input wire logic [nif_pkg::WORD_W-1:0] o_address_word,
    input wire logic [nif_pkg::WORD_W-1:0] o_command_word
);
    import nif_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_decoded_ok)
            && $stable(o_address_word) && $stable(o_command_word))
        else $error("result beat changed while stalled");

    // failed frame carries zero words
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_decoded_ok |-> o_address_word == '0 && o_command_word == '0)
        else $error("failed frame with non-zero words");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // reset empties the block
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

endmodule

bind nec_ir_frame_decoder nif_checker u_nif_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_decoded_ok   (o_decoded_ok),
    .o_address_word (o_address_word),
    .o_command_word (o_command_word)
);

`default_nettype wire
